// ===== design/life_generation_row_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the life generation row engine
// Concurrent checks, clocked and reset-qualified; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_ENGINE_UNIT_ASSERT_SVH
`define LIFE_GENERATION_ROW_ENGINE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LGR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lgr assertion failed");

// next-cycle implication
`define LGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lgr assertion failed");

`else

`define LGR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LGR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/lgr_pkg.sv =====
// ----------------------------------------------------------------------------
// lgr_pkg
// Grid geometry, rule constants and shared types of the life row engine.
// ----------------------------------------------------------------------------
package lgr_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 32;

  localparam int RowW     = 32;  // width of one row request
  localparam int IdxW     = 5;   // output row index width
  localparam int NumCells = (GRID_COLS < RowW) ? GRID_COLS : RowW;
  localparam int RowCntW  = $clog2(GRID_ROWS);
  localparam int NbrCntW  = 4;   // holds up to eight neighbors

  localparam logic [NbrCntW-1:0] BIRTH_COUNT = NbrCntW'(3);
  localparam logic [NbrCntW-1:0] SURVIVE_LOW = NbrCntW'(2);

  localparam int BufDepth = 2;
  localparam int BufPtrW  = 1;
  localparam int BufCntW  = 2;

  // one column as seen by a neighbor cell
  typedef struct packed {
    logic above;
    logic middle;
    logic below;
  } lgr_col_t;

  // control broadcast to every cell
  typedef struct packed {
    logic shift;  // take a new row
    logic clear;  // end of frame, back to empty
    logic flush;  // row below the grid reads dead
  } lgr_ctrl_t;

  // one result request
  typedef struct packed {
    logic [RowW-1:0] cells;
    logic [IdxW-1:0] idx;
    logic            done;
  } lgr_res_t;

endpackage

// ===== design/lgr_cell.sv =====
// ----------------------------------------------------------------------------
// lgr_cell
// One grid column: holds the above and middle cells, applies B3/S23.
// ----------------------------------------------------------------------------
module lgr_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lgr_pkg::lgr_ctrl_t ctrl_i,
  input  logic              row_bit_i,
  input  lgr_pkg::lgr_col_t left_i,
  input  lgr_pkg::lgr_col_t right_i,
  output lgr_pkg::lgr_col_t col_o,
  output logic              next_o
);
  import lgr_pkg::*;

  logic               above_q, above_d;
  logic               middle_q, middle_d;
  logic               below;
  logic [NbrCntW-1:0] nbr_cnt;

  assign below = ctrl_i.flush ? 1'b0 : row_bit_i;
  assign col_o = '{above: above_q, middle: middle_q, below: below};

  assign nbr_cnt = NbrCntW'(left_i.above)  + NbrCntW'(left_i.middle)
                 + NbrCntW'(left_i.below)  + NbrCntW'(right_i.above)
                 + NbrCntW'(right_i.middle) + NbrCntW'(right_i.below)
                 + NbrCntW'(above_q)       + NbrCntW'(below);

  assign next_o = (nbr_cnt == BIRTH_COUNT) || (middle_q && (nbr_cnt == SURVIVE_LOW));

  always_comb begin
    above_d  = above_q;
    middle_d = middle_q;
    if (ctrl_i.clear) begin
      above_d  = 1'b0;
      middle_d = 1'b0;
    end else if (ctrl_i.shift) begin
      above_d  = middle_q;
      middle_d = row_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q  <= 1'b0;
      middle_q <= 1'b0;
    end else begin
      above_q  <= above_d;
      middle_q <= middle_d;
    end
  end

endmodule

// ===== design/lgr_out_buf.sv =====
// ----------------------------------------------------------------------------
// lgr_out_buf
// Two-entry result queue between the cell row and the output channel.
// ----------------------------------------------------------------------------
module lgr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lgr_pkg::lgr_res_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lgr_pkg::lgr_res_t out_data_o
);
  import lgr_pkg::*;

  lgr_res_t           mem_q [BufDepth];
  logic [BufPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [BufPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [BufCntW-1:0] cnt_q, cnt_d;
  logic               pop;

  assign full_o      = (cnt_q == BufCntW'(BufDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + BufCntW'(push_i) - BufCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/life_generation_row_engine_unit.sv =====
// ----------------------------------------------------------------------------
// life_generation_row_engine_unit
// One generation of B3/S23 Life over a bounded grid, streamed a row at a time.
// ----------------------------------------------------------------------------
// Rows of a frame enter top to bottom, one request per cycle while the
// output queue has room and no flush is under way. The first row of a frame
// gives no result; every later row gives the next generation of the row above
// it. After the last row of the frame (row GRID_ROWS-1) the cells, in a flush
// step that takes no input, evaluate that last row against an all-dead row
// below and emit it with frame_done set. After frame_done the block is empty
// again and the next row is row 0 of a new frame. Cells outside the grid read
// dead, no wrap; input bits at or above GRID_COLS are ignored and the matching
// output bits are zero. out_row_index wraps modulo 32.
// ----------------------------------------------------------------------------
module life_generation_row_engine_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lgr_pkg::RowW-1:0]  row_cells_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lgr_pkg::RowW-1:0]  next_row_cells_o,
  output logic [lgr_pkg::IdxW-1:0]  out_row_index_o,
  output logic                      frame_done_o
);
  import lgr_pkg::*;

`include "life_generation_row_engine_unit_assert.svh"

  // frame control: rows taken so far, and the end-of-frame flush cycle
  logic [RowCntW-1:0] rows_q, rows_d;
  logic               flush_q, flush_d;

  logic      in_fire;
  logic      last_row;
  logic      push_row;    // a middle row is finished by the new row below
  logic      push_flush;  // last row finished against a dead row below
  logic      push;
  logic      buf_full;
  lgr_ctrl_t ctrl;
  lgr_res_t  res;
  lgr_res_t  out_res;

  // cell row: each cell sees its neighbors' columns, edges see dead cells
  lgr_col_t            cols [NumCells];
  logic [NumCells-1:0] next_bits;

  assign in_ready_o = !flush_q && !buf_full;
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_row   = (rows_q == RowCntW'(GRID_ROWS - 1));
  assign push_row   = in_fire && (rows_q != '0);
  assign push_flush = flush_q && !buf_full;
  assign push       = push_row || push_flush;

  assign ctrl = '{shift: in_fire, clear: push_flush, flush: flush_q};

  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    lgr_col_t left_col;
    lgr_col_t right_col;

    if (c == 0) begin : g_left_edge
      assign left_col = '0;
    end else begin : g_left_nbr
      assign left_col = cols[c-1];
    end

    if (c == NumCells - 1) begin : g_right_edge
      assign right_col = '0;
    end else begin : g_right_nbr
      assign right_col = cols[c+1];
    end

    lgr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .row_bit_i (row_cells_i[c]),
      .left_i    (left_col),
      .right_i   (right_col),
      .col_o     (cols[c]),
      .next_o    (next_bits[c])
    );
  end

  // result request: normal rows report the row above the incoming one,
  // the flush reports the last grid row itself
  always_comb begin
    res.cells = RowW'(next_bits);
    res.idx   = push_flush ? IdxW'(rows_q) : IdxW'(rows_q - RowCntW'(1));
    res.done  = push_flush;
  end

  always_comb begin
    rows_d  = rows_q;
    flush_d = flush_q;
    if (push_flush) begin
      rows_d  = '0;
      flush_d = 1'b0;
    end else if (in_fire) begin
      if (last_row) begin
        flush_d = 1'b1;  // hold the count; it names the flushed row
      end else begin
        rows_d = rows_q + RowCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      rows_q  <= rows_d;
      flush_q <= flush_d;
    end
  end

  // output queue decouples the cell row from output stalls
  lgr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign next_row_cells_o = out_res.cells;
  assign out_row_index_o  = out_res.idx;
  assign frame_done_o     = out_res.done;

  // no new row is taken while the last row is being flushed
  `LGR_ASSERT_IMPL(a_flush_blocks_input, clk_i, rst_ni, flush_q, !in_ready_o)
  // the last row of a frame always leads into a flush
  `LGR_ASSERT_NEXT(a_last_row_flushes, clk_i, rst_ni, in_fire && last_row, flush_q)
  // a flush leaves the frame empty
  `LGR_ASSERT_NEXT(a_flush_resets, clk_i, rst_ni, push_flush,
                   (rows_q == '0) && !flush_q)
  // the flagged row is always the last grid row
  `LGR_ASSERT_IMPL(a_done_index, clk_i, rst_ni, out_valid_o && frame_done_o,
                   out_row_index_o == IdxW'(GRID_ROWS - 1))

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: life generation row engine testbench
// Streams rows into the engine and checks each next-generation row, with its
// row index and frame-done flag, against a cycle-free B3/S23 row predictor.
// ----------------------------------------------------------------------------
// Frames are 32 rows, top to bottom. The first frame opens with hand-picked
// rows (full and empty rows, edge columns, a blinker, a glider, a block,
// stripes). The rest are random frames, each with its own cell density or
// small shifted patterns, plus the odd all-dead or all-alive row. Both
// handshakes see random idle bursts until the tail of the run, which runs
// at full rate.
// ----------------------------------------------------------------------------
module tb_top;

  import lgr_pkg::*;

  localparam int DirectedRows = 24;
  localparam int FrameCount   = 38;
  localparam int TotalRows    = FrameCount * GRID_ROWS;
  localparam int QuietTail    = 150;  // last requests go without idling
  localparam int DrainCycles  = 20;

  logic            clk_i;
  logic            rst_ni        = 1'b0;
  logic            in_valid_i    = 1'b0;
  logic            in_ready_o;
  logic [RowW-1:0] row_cells_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i   = 1'b0;
  logic [RowW-1:0] next_row_cells_o;
  logic [IdxW-1:0] out_row_index_o;
  logic            frame_done_o;

  life_generation_row_engine_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .row_cells_i      (row_cells_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .next_row_cells_o (next_row_cells_o),
    .out_row_index_o  (out_row_index_o),
    .frame_done_o     (frame_done_o)
  );

  // rows waiting to be sent, and next-generation rows waiting to come back
  logic [RowW-1:0] rows_to_send[$];
  lgr_res_t        gen_rows_due[$];

  // predictor copy of the engine's row window
  logic [RowW-1:0] win_above;
  logic [RowW-1:0] win_middle;
  int              rows_in_frame;

  int   fail_count = 0;
  logic row_taken  = 1'b0;  // input request accepted at the last rising edge
  int   send_gap   = 0;
  int   stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Row predictor
  // --------------------------------------------------------------------------

  // mask of the columns that exist in the grid
  function automatic logic [RowW-1:0] grid_mask();
    logic [RowW-1:0] m;
    m = '0;
    for (int c = 0; c < NumCells; c++) m[c] = 1'b1;
    return m;
  endfunction

  // anything off the grid edge reads dead
  function automatic int live_at(logic [RowW-1:0] row, int col);
    if (col < 0 || col >= NumCells) return 0;
    return int'(row[col]);
  endfunction

  // B3/S23 on the middle row given its two neighbors
  function automatic logic [RowW-1:0] evolve_row(logic [RowW-1:0] above,
                                                 logic [RowW-1:0] middle,
                                                 logic [RowW-1:0] below);
    logic [RowW-1:0] nxt;
    int              nbrs;
    nxt = '0;
    for (int c = 0; c < NumCells; c++) begin
      nbrs = live_at(middle, c - 1) + live_at(middle, c + 1);
      for (int d = -1; d <= 1; d++) begin
        nbrs += live_at(above, c + d) + live_at(below, c + d);
      end
      if (middle[c])
        nxt[c] = (nbrs == int'(SURVIVE_LOW)) || (nbrs == int'(BIRTH_COUNT));
      else
        nxt[c] = (nbrs == int'(BIRTH_COUNT));
    end
    return nxt & grid_mask();
  endfunction

  // One accepted row: the first row of a frame only fills the window; later
  // rows release the row above them; the bottom row also releases itself
  // against a dead row below, flagged done, and the window empties.
  task automatic predict_rows(logic [RowW-1:0] row_in);
    logic [RowW-1:0] cur;
    lgr_res_t        res;
    cur = row_in & grid_mask();
    if (rows_in_frame == 0) begin
      win_above     = '0;
      win_middle    = cur;
      rows_in_frame = 1;
    end else begin
      res.cells = evolve_row(win_above, win_middle, cur);
      res.idx   = IdxW'(rows_in_frame - 1);
      res.done  = 1'b0;
      gen_rows_due.push_back(res);
      if (rows_in_frame >= GRID_ROWS - 1) begin
        res.cells = evolve_row(win_middle, cur, '0);
        res.idx   = IdxW'(rows_in_frame);
        res.done  = 1'b1;
        gen_rows_due.push_back(res);
        win_above     = '0;
        win_middle    = '0;
        rows_in_frame = 0;
      end else begin
        win_above     = win_middle;
        win_middle    = cur;
        rows_in_frame = rows_in_frame + 1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: holds a request until accepted, then idles or sends next
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || row_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (rows_to_send.size() > QuietTail && $urandom_range(0, 7) == 0) begin
        send_gap   = $urandom_range(1, 9) - 1;
        in_valid_i <= 1'b0;
      end else if (rows_to_send.size() > 0) begin
        in_valid_i  <= 1'b1;
        row_cells_i <= rows_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: random stall bursts, full rate in the tail
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (rows_to_send.size() > QuietTail && $urandom_range(0, 5) == 0) begin
        stall_left  = $urandom_range(1, 9) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on input requests, checks output requests in order.
  // Prediction goes first so a same-edge result would still find its entry.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    lgr_res_t want;
    row_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_rows(row_cells_i);
      if (out_valid_o && out_ready_i) begin
        if (gen_rows_due.size() == 0) begin
          $error("unexpected result row: cells %h index %0d done %b",
                 next_row_cells_o, out_row_index_o, frame_done_o);
          fail_count++;
        end else begin
          want = gen_rows_due.pop_front();
          if (next_row_cells_o !== want.cells) begin
            $error("next_row_cells: expected %h, actual %h", want.cells, next_row_cells_o);
            fail_count++;
          end
          if (out_row_index_o !== want.idx) begin
            $error("out_row_index: expected %0d, actual %0d", want.idx, out_row_index_o);
            fail_count++;
          end
          if (frame_done_o !== want.done) begin
            $error("frame_done: expected %b, actual %b", want.done, frame_done_o);
            fail_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [RowW-1:0] directed_rows[DirectedRows];
    logic [RowW-1:0] r;
    int              density;
    int              shift;

    win_above     = '0;
    win_middle    = '0;
    rows_in_frame = 0;

    // top of the first frame: edges, still lifes and oscillators
    directed_rows = '{
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
      32'h8000_0000, 32'h8000_0001, 32'h0000_0007, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0002, 32'h0000_0004, 32'h0000_0007,
      32'h0000_0000, 32'hE000_0000, 32'h0000_0000, 32'hAAAA_AAAA,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0001_8000,
      32'h0001_8000, 32'h0000_0000, 32'hC000_0003, 32'hFFFF_FFFF
    };
    foreach (directed_rows[i]) rows_to_send.push_back(directed_rows[i]);

    density = 1;
    for (int i = DirectedRows; i < TotalRows; i++) begin
      // each frame gets its own flavor
      if (i % GRID_ROWS == 0) density = $urandom_range(0, 3);
      case (density)
        0:       r = $urandom() & $urandom() & $urandom();
        1:       r = $urandom();
        2:       r = $urandom() | $urandom();
        default: begin
          // small shapes slid across the row, edge columns included
          shift = $urandom_range(0, RowW - 1);
          case ($urandom_range(0, 3))
            0:       r = 32'h0000_0007;
            1:       r = 32'h0000_0005;
            2:       r = 32'h0000_0003;
            default: r = 32'h0000_0000;
          endcase
          r = (r << shift) | (r >> (RowW - shift));
        end
      endcase
      // occasional fully dead or fully alive row, bottom row included
      case ($urandom_range(0, 19))
        0:       r = '0;
        1:       r = '1;
        default: ;
      endcase
      rows_to_send.push_back(r);
    end

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    while (rows_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    while (gen_rows_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && gen_rows_due.size() == 0) begin
      $display("life_generation_row_engine_unit verification clean");
    end else begin
      $display("life_generation_row_engine_unit verification failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("life_generation_row_engine_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/lgr_pkg.sv
design/lgr_cell.sv
design/lgr_out_buf.sv
design/life_generation_row_engine_unit.sv
verif/tb_top.sv
